// ----- design/integral_image_8bit_assert.svh -----
// Assertion macros for the integral image block.
// Included by the top level; no other dependencies.
`ifndef INTEGRAL_IMAGE_8BIT_ASSERT_SVH
`define INTEGRAL_IMAGE_8BIT_ASSERT_SVH

`ifndef SYNTH

// Check that an expression holds on every clock edge out of reset.
`define IIMG_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: expression must always hold");

// Check that a condition implies a consequence in the same cycle.
`define IIMG_ASSERT_IMPLY(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("assertion failed: implication violated");

`else

`define IIMG_ASSERT_ALWAYS(label, clk, rstn, expr)

`define IIMG_ASSERT_IMPLY(label, clk, rstn, cond, cons)

`endif

`endif

// ----- design/iimg_pkg.sv -----
// Shared types, constants and helpers for the integral image block.
// No dependencies; every design module imports this package.
package iimg_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIXEL_W    = 8;
    localparam int ROW_SUM_W  = 18;
    localparam int AREA_W     = 28;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int SIZE_RESET = 1024;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position flags that travel with each word.
    typedef struct packed {
        logic first_row;
        logic row_end;
        logic image_end;
    } iimg_flags_t;

    localparam int FLAGS_W = $bits(iimg_flags_t);

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } iimg_qstat_t;

    // Last valid index for a size register: zero counts as one, large values saturate.
    function automatic int size_last(input logic [CFG_DATA_W-1:0] v, input int maxv);
        int r;
        if (v == '0) begin
            r = 0;
        end else if (int'(v) > maxv) begin
            r = maxv - 1;
        end else begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

endpackage

// ----- design/integral_image_8bit.sv -----
// Top level of the integral image (summed-area table) block for 8-bit pixels.
// Depends on iimg_pkg, iimg_front, iimg_queue, iimg_back and the assertion header.
//
//  channel  | direction | handshake           | words
//  ---------+-----------+---------------------+----------------------------------
//  s_       | in        | s_valid / s_ready   | s_pixel, raster order
//  m_       | out       | m_valid / m_ready   | m_area_sum, m_row_end, m_image_end
//  cfg_     | in        | cfg_wr_en           | cfg_index, cfg_data (no read-back)
//
//  Throughput: one pixel per cycle sustained while m_ready stays high, set by the
//  single line store port pair (one read and one write each cycle).
//  Path: an accepted pixel passes the queue entry, the back stage registers and
//  the output register before its result shows on m_valid.
//  Reset: aresetn low at a clock edge clears counters, sizes (1024 x 1024) and
//  queue; the line store needs no clearing, as the first row ignores what it reads.
//  Stalls: the four-word queue lets the input keep flowing while m_ready is low;
//  s_ready drops only when the queue is full.
`include "integral_image_8bit_assert.svh"

module integral_image_8bit #(
    parameter int MAX_WIDTH  = iimg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iimg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iimg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iimg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [iimg_pkg::PIXEL_W-1:0]        s_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [iimg_pkg::AREA_W-1:0]         m_area_sum,
    output logic                                m_row_end,
    output logic                                m_image_end
);
    import iimg_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ITEM_W = COL_W + ROW_SUM_W + FLAGS_W;

    logic                 push;
    logic                 pop;
    logic [COL_W-1:0]     f_col;
    logic [ROW_SUM_W-1:0] f_rsum;
    iimg_flags_t          f_flags;
    logic [ITEM_W-1:0]    q_in;
    logic [ITEM_W-1:0]    q_out;
    iimg_qstat_t          q_stat;
    logic [COL_W-1:0]     q_col;
    logic [ROW_SUM_W-1:0] q_rsum;
    iimg_flags_t          q_flags;

    // Accept a word whenever the queue has room.
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // Tag the pixel with its column, row sum so far and position flags.
    iimg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .pixel      (s_pixel),
        .item_col   (f_col),
        .item_rsum  (f_rsum),
        .item_flags (f_flags)
    );

    assign q_in = {f_col, f_rsum, f_flags};

    // Decouple the front from stalls on the result side.
    iimg_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    assign {q_col, q_rsum, q_flags} = q_out;

    // Add the row above from the line store and write the new value back.
    iimg_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_stat.empty),
        .pop         (pop),
        .q_col       (q_col),
        .q_rsum      (q_rsum),
        .q_flags     (q_flags),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_area_sum  (m_area_sum),
        .m_row_end   (m_row_end),
        .m_image_end (m_image_end)
    );

    // The queue can never be both full and empty.
    `IIMG_ASSERT_ALWAYS(a_queue_state, aclk, aresetn, !(q_stat.full && q_stat.empty))
    // The last pixel of an image is always the last pixel of its row.
    `IIMG_ASSERT_IMPLY(a_image_end_row, aclk, aresetn, m_valid && m_image_end, m_row_end)
    // The back part only takes from a queue that holds a word.
    `IIMG_ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn, pop, !q_stat.empty)

endmodule

// ----- design/iimg_front.sv -----
// Front part: holds the size registers and position counters, tags each pixel.
// Depends on iimg_pkg.
module iimg_front #(
    parameter int MAX_WIDTH  = iimg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iimg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [iimg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [iimg_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    push,
    input  logic [iimg_pkg::PIXEL_W-1:0]            pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]            item_col,
    output logic [iimg_pkg::ROW_SUM_W-1:0]          item_rsum,
    output iimg_pkg::iimg_flags_t                   item_flags
);
    import iimg_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SIZE_RESET_W = (SIZE_RESET < MAX_WIDTH) ? SIZE_RESET : MAX_WIDTH;
    localparam int SIZE_RESET_H = (SIZE_RESET < MAX_HEIGHT) ? SIZE_RESET : MAX_HEIGHT;

    logic [COL_W-1:0]     last_col_reg, last_col_next;
    logic [ROW_W-1:0]     last_row_reg, last_row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_SUM_W-1:0] rsum_reg, rsum_next;
    logic [ROW_SUM_W-1:0] rsum_sum;
    logic                 row_end;
    logic                 image_end;

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_IMAGE_WIDTH:  last_col_next = COL_W'(size_last(cfg_data, MAX_WIDTH));
                CFG_IMAGE_HEIGHT: last_row_next = ROW_W'(size_last(cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // A position past a shrunk size counts as the last one.
    assign row_end   = (col_reg >= last_col_reg);
    assign image_end = row_end && (row_reg >= last_row_reg);
    assign rsum_sum  = rsum_reg + ROW_SUM_W'(pixel);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        rsum_next = rsum_reg;
        if (push) begin
            if (row_end) begin
                col_next  = '0;
                rsum_next = '0;
                row_next  = image_end ? '0 : row_reg + 1'b1;
            end else begin
                col_next  = col_reg + 1'b1;
                rsum_next = rsum_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= COL_W'(SIZE_RESET_W - 1);
            last_row_reg <= ROW_W'(SIZE_RESET_H - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            rsum_reg     <= '0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            rsum_reg     <= rsum_next;
        end
    end

    assign item_col             = col_reg;
    assign item_rsum            = rsum_sum;
    assign item_flags.first_row = (row_reg == '0);
    assign item_flags.row_end   = row_end;
    assign item_flags.image_end = image_end;

endmodule

// ----- design/iimg_queue.sv -----
// Short first-in first-out queue between the front and back parts.
// Depends on iimg_pkg.
module iimg_queue #(
    parameter int DATA_W = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [DATA_W-1:0]           push_data,
    input  logic                        pop,
    output logic [DATA_W-1:0]           pop_data,
    output iimg_pkg::iimg_qstat_t       stat
);
    import iimg_pkg::*;

    logic [DATA_W-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- design/iimg_back.sv -----
// Back part: line store read, add with the row above, write back, output register.
// Depends on iimg_pkg.
module iimg_back #(
    parameter int MAX_WIDTH = iimg_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    output logic                                pop,
    input  logic [$clog2(MAX_WIDTH)-1:0]        q_col,
    input  logic [iimg_pkg::ROW_SUM_W-1:0]      q_rsum,
    input  iimg_pkg::iimg_flags_t               q_flags,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [iimg_pkg::AREA_W-1:0]         m_area_sum,
    output logic                                m_row_end,
    output logic                                m_image_end
);
    import iimg_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [AREA_W-1:0]    line_mem [MAX_WIDTH];
    logic [AREA_W-1:0]    rd_data_reg;
    logic                 byp_hit_reg;
    logic [AREA_W-1:0]    byp_data_reg;

    logic                 b_vld_reg, b_vld_next;
    logic [COL_W-1:0]     b_col_reg;
    logic [ROW_SUM_W-1:0] b_rsum_reg;
    iimg_flags_t          b_flags_reg;

    logic                 out_vld_reg, out_vld_next;
    logic [AREA_W-1:0]    out_area_reg;
    logic                 out_row_end_reg;
    logic                 out_image_end_reg;

    logic                 out_free;
    logic                 b_move;
    logic [AREA_W-1:0]    above;
    logic [AREA_W-1:0]    area_b;

    assign out_free = !out_vld_reg || m_ready;
    assign b_move   = b_vld_reg && out_free;
    assign pop      = !q_empty && (!b_vld_reg || b_move);

    // Forward the word written in the read cycle: the store returns old data then.
    always_comb begin
        if (b_flags_reg.first_row) begin
            above = '0;
        end else if (byp_hit_reg) begin
            above = byp_data_reg;
        end else begin
            above = rd_data_reg;
        end
    end

    assign area_b = above + AREA_W'(b_rsum_reg);

    always_comb begin
        b_vld_next = b_vld_reg;
        if (pop) begin
            b_vld_next = 1'b1;
        end else if (b_move) begin
            b_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (b_move) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            b_vld_reg   <= b_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            line_mem[b_col_reg] <= area_b;
        end
        if (pop) begin
            rd_data_reg <= line_mem[q_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b_col_reg    <= q_col;
            b_rsum_reg   <= q_rsum;
            b_flags_reg  <= q_flags;
            byp_hit_reg  <= b_move && (b_col_reg == q_col);
            byp_data_reg <= area_b;
        end
        if (b_move) begin
            out_area_reg      <= area_b;
            out_row_end_reg   <= b_flags_reg.row_end;
            out_image_end_reg <= b_flags_reg.image_end;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_area_sum  = out_area_reg;
    assign m_row_end   = out_row_end_reg;
    assign m_image_end = out_image_end_reg;

endmodule
